// ===== rtl/sdiu_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the sprite draw unit.
package sdiu_pkg;

   // Memory and frame geometry
   localparam int MEM_BYTES      = 4096;
   localparam int MEM_AW         = 12;
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 32;
   localparam int MIN_WIDTH      = 8;
   localparam int MIN_HEIGHT     = 16;
   localparam int CFG_W          = 7;

   localparam logic [11:0] PC_RESET = 12'h200;

   // Item actions
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_EXEC  = 2'd1;
   localparam logic [1:0] ACT_PIXEL = 2'd2;
   localparam logic [1:0] ACT_REG   = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;

   // Opcode classes (top nibble) and special words
   localparam logic [3:0]  OPC_JUMP  = 4'h1;
   localparam logic [3:0]  OPC_SET   = 4'h6;
   localparam logic [3:0]  OPC_ADD   = 4'h7;
   localparam logic [3:0]  OPC_INDEX = 4'hA;
   localparam logic [3:0]  OPC_DRAW  = 4'hD;
   localparam logic [15:0] OP_CLEAR  = 16'h00E0;
   localparam logic [3:0]  FLAG_REG  = 4'hF;

   // Datapath commands
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_LOAD_MEM,
      CMD_EXEC,
      CMD_CLEAR_STEP,
      CMD_DRAW_INIT,
      CMD_MOD_X,
      CMD_MOD_Y,
      CMD_ROW_READ,
      CMD_PIX_ADDR,
      CMD_PIX_READ,
      CMD_PIX_WRITE,
      CMD_HIT_STORE,
      CMD_RESP_ADDR,
      CMD_RESP_READ,
      CMD_RESP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       is_clear;
      logic       is_draw;
      logic       rows_zero;
      logic       clr_last;
      logic       mod_busy;
      logic       bit_set;
      logic       col_last;
      logic       row_last;
   } dp_status_type;

endpackage

// ===== rtl/sdiu_datapath.sv =====
// Datapath: machine registers, program memory, frame store, modulo unit and result registers.
module sdiu_datapath #(
   parameter int MAX_WIDTH  = sdiu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sdiu_pkg::DEF_MAX_HEIGHT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_action,
   input  logic [15:0]              req_opcode,
   input  logic [11:0]              req_mem_address,
   input  logic [7:0]               req_mem_data,
   input  logic [5:0]               req_pixel_x,
   input  logic [4:0]               req_pixel_y,
   input  logic [3:0]               req_reg_select,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [sdiu_pkg::CFG_W-1:0] csr_wdata,
   input  sdiu_pkg::dp_cmd_type     cmd,
   output sdiu_pkg::dp_status_type  status,
   output logic [11:0]              rsp_pc_value,
   output logic [11:0]              rsp_index_value,
   output logic [7:0]               rsp_reg_value,
   output logic                     rsp_pixel_on,
   output logic                     rsp_collision
);

   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int H_W    = $clog2(MAX_HEIGHT + 1);
   localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int CELL_W = $clog2(CELLS);
   localparam int PROD_W = W_W + H_W;

   // Captured item
   logic [1:0]  act_ff;
   logic [15:0] op_ff;
   logic [11:0] maddr_ff;
   logic [7:0]  mdata_ff;
   logic [5:0]  px_ff;
   logic [4:0]  py_ff;
   logic [3:0]  rs_ff;

   // Machine state
   logic [W_W-1:0] width_ff;
   logic [H_W-1:0] height_ff;
   logic [11:0]    pc_ff;
   logic [11:0]    index_ff;
   logic [7:0]     greg_ff [16];

   // Memories
   logic [7:0]  mem_ff [sdiu_pkg::MEM_BYTES];
   logic [7:0]  mem_rdata_ff;
   logic        frame_ff [CELLS];
   logic        fr_rdata_ff;
   logic [CELL_W-1:0] cell_ff;
   logic              in_range_ff;
   logic [CELL_W-1:0] clr_cnt_ff;

   // Modulo unit
   logic       mod_busy_ff;
   logic [2:0] mod_cnt_ff;
   logic [7:0] mod_rem_ff;
   logic [7:0] mod_div_ff;
   logic [7:0] mod_den_ff;
   logic       mod_to_y_ff;

   // Draw walk
   logic [W_W-1:0] x0_ff;
   logic [H_W-1:0] y0_ff;
   logic [3:0]     row_ff;
   logic [2:0]     col_ff;
   logic           hit_ff;

   // Result registers
   logic [11:0] rsp_pc_ff;
   logic [11:0] rsp_index_ff;
   logic [7:0]  rsp_reg_ff;
   logic        rsp_pixel_ff;
   logic        rsp_collision_ff;

   logic [3:0] op_x;
   logic [3:0] op_y;
   logic [3:0] rows;
   logic [3:0] gr_idx;
   logic [7:0] gr_rd;
   logic [7:0] csr_w_val;
   logic [7:0] csr_h_val;
   logic [W_W-1:0] width_in;
   logic [H_W-1:0] height_in;
   logic [W_W:0]   xs_sum;
   logic [W_W:0]   xs_wrap;
   logic [H_W:0]   ys_sum;
   logic [H_W:0]   ys_wrap;
   logic [PROD_W-1:0] draw_cell;
   logic [PROD_W-1:0] resp_cell;
   logic              resp_in_range;
   logic [11:0]       mem_raddr;
   logic              fr_we;
   logic [CELL_W-1:0] fr_waddr;
   logic              fr_wdata;
   logic [8:0]        mod_trial;
   logic [8:0]        mod_rem_in;
   logic              clr_last;

   assign op_x = op_ff[11:8];
   assign op_y = op_ff[7:4];
   assign rows = op_ff[3:0];

   // Select the one general register read port
   always_comb begin
      case (cmd.op)
         sdiu_pkg::CMD_MOD_Y:     gr_idx = op_y;
         sdiu_pkg::CMD_RESP_LOAD: gr_idx = rs_ff;
         default:                 gr_idx = op_x;
      endcase
   end
   assign gr_rd = greg_ff[gr_idx];

   // Saturate frame size writes into the supported range (height from the low six bits only)
   assign csr_w_val = {1'b0, csr_wdata};
   assign csr_h_val = {2'b00, csr_wdata[5:0]};
   always_comb begin
      if (csr_w_val < 8'(sdiu_pkg::MIN_WIDTH)) begin
         width_in = W_W'(sdiu_pkg::MIN_WIDTH);
      end else if (csr_w_val > 8'(MAX_WIDTH)) begin
         width_in = W_W'(MAX_WIDTH);
      end else begin
         width_in = W_W'(csr_w_val);
      end
      if (csr_h_val < 8'(sdiu_pkg::MIN_HEIGHT)) begin
         height_in = H_W'(sdiu_pkg::MIN_HEIGHT);
      end else if (csr_h_val > 8'(MAX_HEIGHT)) begin
         height_in = H_W'(MAX_HEIGHT);
      end else begin
         height_in = H_W'(csr_h_val);
      end
   end

   // Wrap sprite pixel coordinates: both sums stay below twice the frame size
   assign xs_sum  = (W_W+1)'(x0_ff) + (W_W+1)'(col_ff);
   assign xs_wrap = (xs_sum >= {1'b0, width_ff}) ? xs_sum - {1'b0, width_ff} : xs_sum;
   assign ys_sum  = (H_W+1)'(y0_ff) + (H_W+1)'(row_ff);
   assign ys_wrap = (ys_sum >= {1'b0, height_ff}) ? ys_sum - {1'b0, height_ff} : ys_sum;
   assign draw_cell = PROD_W'(ys_wrap[H_W-1:0]) * PROD_W'(width_ff)
                    + PROD_W'(xs_wrap[W_W-1:0]);

   // Pixel reported with the result
   assign resp_cell     = PROD_W'(py_ff) * PROD_W'(width_ff) + PROD_W'(px_ff);
   assign resp_in_range = (W_W'(px_ff) < width_ff) && (H_W'(py_ff) < height_ff);

   assign mem_raddr = index_ff + {8'b0, row_ff};
   assign clr_last  = (clr_cnt_ff == CELL_W'(CELLS - 1));

   // Frame write port: clear sweep or sprite toggle
   always_comb begin
      fr_we    = 1'b0;
      fr_waddr = cell_ff;
      fr_wdata = ~fr_rdata_ff;
      case (cmd.op)
         sdiu_pkg::CMD_CLEAR_STEP: begin
            fr_we    = 1'b1;
            fr_waddr = clr_cnt_ff;
            fr_wdata = 1'b0;
         end
         sdiu_pkg::CMD_PIX_WRITE: begin
            fr_we = 1'b1;
         end
         default: begin
            fr_we = 1'b0;
         end
      endcase
   end

   // Frame store
   always_ff @(posedge clock) begin
      if (fr_we) begin
         frame_ff[fr_waddr] <= fr_wdata;
      end
      fr_rdata_ff <= frame_ff[cell_ff];
   end

   // Program memory
   always_ff @(posedge clock) begin
      if (cmd.op == sdiu_pkg::CMD_LOAD_MEM) begin
         mem_ff[maddr_ff] <= mdata_ff;
      end
      mem_rdata_ff <= mem_ff[mem_raddr];
   end

   // One restoring remainder step per cycle
   assign mod_trial  = {mod_rem_ff, mod_div_ff[7]};
   assign mod_rem_in = (mod_trial >= {1'b0, mod_den_ff}) ? mod_trial - {1'b0, mod_den_ff}
                                                         : mod_trial;

   // Registers and command execution
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= W_W'(MAX_WIDTH);
         height_ff   <= H_W'(MAX_HEIGHT);
         pc_ff       <= sdiu_pkg::PC_RESET;
         index_ff    <= '0;
         clr_cnt_ff  <= '0;
         mod_busy_ff <= 1'b0;
         mod_cnt_ff  <= '0;
         for (int i = 0; i < 16; i++) begin
            greg_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            if (csr_index == sdiu_pkg::CSR_FRAME_WIDTH) begin
               width_ff <= width_in;
            end else if (csr_index == sdiu_pkg::CSR_FRAME_HEIGHT) begin
               height_ff <= height_in;
            end
         end

         case (cmd.op)
            sdiu_pkg::CMD_CAPTURE: begin
               act_ff   <= req_action;
               op_ff    <= req_opcode;
               maddr_ff <= req_mem_address;
               mdata_ff <= req_mem_data;
               px_ff    <= req_pixel_x;
               py_ff    <= req_pixel_y;
               rs_ff    <= req_reg_select;
            end
            sdiu_pkg::CMD_EXEC: begin
               case (op_ff[15:12])
                  sdiu_pkg::OPC_JUMP:  pc_ff <= op_ff[11:0];
                  sdiu_pkg::OPC_SET:   greg_ff[op_x] <= op_ff[7:0];
                  sdiu_pkg::OPC_ADD:   greg_ff[op_x] <= gr_rd + op_ff[7:0];
                  sdiu_pkg::OPC_INDEX: index_ff <= op_ff[11:0];
                  default: ;
               endcase
            end
            sdiu_pkg::CMD_CLEAR_STEP: begin
               clr_cnt_ff <= clr_last ? '0 : clr_cnt_ff + 1'b1;
            end
            sdiu_pkg::CMD_DRAW_INIT: begin
               row_ff <= '0;
               col_ff <= '0;
               hit_ff <= 1'b0;
            end
            sdiu_pkg::CMD_MOD_X, sdiu_pkg::CMD_MOD_Y: begin
               mod_busy_ff <= 1'b1;
               mod_cnt_ff  <= '0;
               mod_rem_ff  <= '0;
               mod_div_ff  <= gr_rd;
               mod_to_y_ff <= (cmd.op == sdiu_pkg::CMD_MOD_Y);
               mod_den_ff  <= (cmd.op == sdiu_pkg::CMD_MOD_Y) ? 8'(height_ff) : 8'(width_ff);
            end
            sdiu_pkg::CMD_PIX_ADDR: begin
               if (status.bit_set) begin
                  cell_ff <= CELL_W'(draw_cell);
               end else if (status.col_last) begin
                  col_ff <= '0;
                  row_ff <= row_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            sdiu_pkg::CMD_PIX_WRITE: begin
               hit_ff <= hit_ff | fr_rdata_ff;
               if (status.col_last) begin
                  col_ff <= '0;
                  row_ff <= row_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            sdiu_pkg::CMD_HIT_STORE: begin
               greg_ff[sdiu_pkg::FLAG_REG] <= {7'b0, hit_ff};
            end
            sdiu_pkg::CMD_RESP_ADDR: begin
               cell_ff     <= CELL_W'(resp_cell);
               in_range_ff <= resp_in_range;
            end
            sdiu_pkg::CMD_RESP_LOAD: begin
               rsp_pc_ff        <= pc_ff;
               rsp_index_ff     <= index_ff;
               rsp_reg_ff       <= gr_rd;
               rsp_pixel_ff     <= in_range_ff & fr_rdata_ff;
               rsp_collision_ff <= greg_ff[sdiu_pkg::FLAG_REG][0];
            end
            default: ;
         endcase

         // Advance the modulo unit and drop the remainder into its target
         if (mod_busy_ff) begin
            mod_rem_ff <= mod_rem_in[7:0];
            mod_div_ff <= {mod_div_ff[6:0], 1'b0};
            mod_cnt_ff <= mod_cnt_ff + 1'b1;
            if (mod_cnt_ff == 3'd7) begin
               mod_busy_ff <= 1'b0;
               if (mod_to_y_ff) begin
                  y0_ff <= H_W'(mod_rem_in);
               end else begin
                  x0_ff <= W_W'(mod_rem_in);
               end
            end
         end
      end
   end

   // Status to the controller
   assign status.action    = act_ff;
   assign status.is_clear  = (op_ff == sdiu_pkg::OP_CLEAR);
   assign status.is_draw   = (op_ff[15:12] == sdiu_pkg::OPC_DRAW);
   assign status.rows_zero = (rows == 4'd0);
   assign status.clr_last  = clr_last;
   assign status.mod_busy  = mod_busy_ff;
   assign status.bit_set   = mem_rdata_ff[3'd7 - col_ff];
   assign status.col_last  = (col_ff == 3'd7);
   assign status.row_last  = (row_ff == rows - 4'd1);

   assign rsp_pc_value    = rsp_pc_ff;
   assign rsp_index_value = rsp_index_ff;
   assign rsp_reg_value   = rsp_reg_ff;
   assign rsp_pixel_on    = rsp_pixel_ff;
   assign rsp_collision   = rsp_collision_ff;

endmodule

// ===== rtl/sdiu_controller.sv =====
// Controller: sequences reset clear, actions, the sprite walk and result delivery.
module sdiu_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sdiu_pkg::dp_status_type status,
   output sdiu_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_CLEAR,
      S_MODX,
      S_MODX_WAIT,
      S_MODY,
      S_MODY_WAIT,
      S_ROW_READ,
      S_PIX_ADDR,
      S_PIX_READ,
      S_PIX_WRITE,
      S_HIT,
      S_RESP_ADDR,
      S_RESP_READ,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state, commands and result valid
   always_comb begin
      state_in     = state_ff;
      cmd.op       = sdiu_pkg::CMD_NONE;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_INIT: begin
            cmd.op = sdiu_pkg::CMD_CLEAR_STEP;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = sdiu_pkg::CMD_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESP_ADDR;
            unique case (status.action)
               sdiu_pkg::ACT_LOAD: cmd.op = sdiu_pkg::CMD_LOAD_MEM;
               sdiu_pkg::ACT_EXEC: begin
                  if (status.is_clear) begin
                     state_in = S_CLEAR;
                  end else if (status.is_draw) begin
                     cmd.op   = sdiu_pkg::CMD_DRAW_INIT;
                     state_in = status.rows_zero ? S_HIT : S_MODX;
                  end else begin
                     cmd.op = sdiu_pkg::CMD_EXEC;
                  end
               end
               default: cmd.op = sdiu_pkg::CMD_NONE;
            endcase
         end
         S_CLEAR: begin
            cmd.op = sdiu_pkg::CMD_CLEAR_STEP;
            if (status.clr_last) begin
               state_in = S_RESP_ADDR;
            end
         end
         S_MODX: begin
            cmd.op   = sdiu_pkg::CMD_MOD_X;
            state_in = S_MODX_WAIT;
         end
         S_MODX_WAIT: begin
            if (!status.mod_busy) begin
               state_in = S_MODY;
            end
         end
         S_MODY: begin
            cmd.op   = sdiu_pkg::CMD_MOD_Y;
            state_in = S_MODY_WAIT;
         end
         S_MODY_WAIT: begin
            if (!status.mod_busy) begin
               state_in = S_ROW_READ;
            end
         end
         S_ROW_READ: begin
            cmd.op   = sdiu_pkg::CMD_ROW_READ;
            state_in = S_PIX_ADDR;
         end
         S_PIX_ADDR: begin
            cmd.op = sdiu_pkg::CMD_PIX_ADDR;
            if (status.bit_set) begin
               state_in = S_PIX_READ;
            end else if (status.col_last) begin
               state_in = status.row_last ? S_HIT : S_ROW_READ;
            end
         end
         S_PIX_READ: begin
            cmd.op   = sdiu_pkg::CMD_PIX_READ;
            state_in = S_PIX_WRITE;
         end
         S_PIX_WRITE: begin
            cmd.op = sdiu_pkg::CMD_PIX_WRITE;
            if (status.col_last) begin
               state_in = status.row_last ? S_HIT : S_ROW_READ;
            end else begin
               state_in = S_PIX_ADDR;
            end
         end
         S_HIT: begin
            cmd.op   = sdiu_pkg::CMD_HIT_STORE;
            state_in = S_RESP_ADDR;
         end
         S_RESP_ADDR: begin
            cmd.op   = sdiu_pkg::CMD_RESP_ADDR;
            state_in = S_RESP_READ;
         end
         S_RESP_READ: begin
            cmd.op   = sdiu_pkg::CMD_RESP_READ;
            state_in = S_RESP;
         end
         S_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = sdiu_pkg::CMD_RESP_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == sdiu_pkg::CMD_RESP_LOAD |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending result");

   // A frame toggle always follows its read cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == sdiu_pkg::CMD_PIX_WRITE |-> $past(cmd.op) == sdiu_pkg::CMD_PIX_READ)
      else $error("frame write without a preceding read");

   // An accepted item is dispatched next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_DISPATCH)
      else $error("accepted item not dispatched");

   // The modulo unit only runs while the controller waits on it
   assert property (@(posedge clock) disable iff (reset)
      status.mod_busy |-> (state_ff == S_MODX_WAIT || state_ff == S_MODY_WAIT))
      else $error("modulo unit busy outside its wait states");

endmodule

// ===== rtl/sprite_draw_instruction_unit.sv =====
// Top level of the sprite draw instruction unit: controller plus datapath.
//
// Usage: each item on the req_ channel (valid/ready) is one action: load a memory
// byte, execute one instruction, read a pixel or read a register. Every item gives
// exactly one result on the rsp_ channel with the program counter, index register,
// the selected register, the selected pixel and the collision flag after the action.
// The csr_ port writes frame width (index 0) and frame height (index 1); values are
// saturated into the supported range, height from its low six bits only, and take
// effect at once, also on an item in flight. Clear screen adds a sweep over every
// frame cell (MAX_WIDTH*MAX_HEIGHT). Sprite draw adds the two coordinate remainders
// (8-step modulo unit) and the flag write, plus, per row, a sprite byte read and, per
// lit sprite pixel, a read-modify-write of the frame store. One item is in flight.
// After reset the frame store is swept clear with req_ready low. A finished result
// sits in an output register; the next item is accepted while it waits, and only
// the following result stalls behind it.
module sprite_draw_instruction_unit #(
   parameter int MAX_WIDTH  = sdiu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sdiu_pkg::DEF_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_action,
   input  logic [15:0]                req_opcode,
   input  logic [11:0]                req_mem_address,
   input  logic [7:0]                 req_mem_data,
   input  logic [5:0]                 req_pixel_x,
   input  logic [4:0]                 req_pixel_y,
   input  logic [3:0]                 req_reg_select,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [11:0]                rsp_pc_value,
   output logic [11:0]                rsp_index_value,
   output logic [7:0]                 rsp_reg_value,
   output logic                       rsp_pixel_on,
   output logic                       rsp_collision,
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [sdiu_pkg::CFG_W-1:0] csr_wdata
);

   sdiu_pkg::dp_cmd_type    cmd;
   sdiu_pkg::dp_status_type status;

   sdiu_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdiu_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_opcode       (req_opcode),
      .req_mem_address  (req_mem_address),
      .req_mem_data     (req_mem_data),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_reg_select   (req_reg_select),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_pc_value     (rsp_pc_value),
      .rsp_index_value  (rsp_index_value),
      .rsp_reg_value    (rsp_reg_value),
      .rsp_pixel_on     (rsp_pixel_on),
      .rsp_collision    (rsp_collision)
   );

endmodule
